// ===== hw/rtl/efd_pkg.sv =====
// Shared constants and types of the escaped frame deframer.
package efd_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 6;
	localparam int M_TDATA_W   = 16;
	localparam int M_PAD_W     = M_TDATA_W - LEN_W - BYTE_W;

	localparam logic [BYTE_W-1:0] ESC_CODE   = 8'h80;
	localparam logic [BYTE_W-1:0] START_CODE = 8'h81;
	localparam logic [BYTE_W-1:0] END_CODE   = 8'h82;

	// Parser to store/drain unit
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [BYTE_W-1:0] wr_data;
		logic              start;
		logic [LEN_W-1:0]  start_len;
	} efd_ctrl_t;

endpackage

// ===== hw/rtl/efd_drain.sv =====
// Frame store memory and the unit that reads a good frame out as a run.
module efd_drain (
	input  logic                         clk,
	input  logic                         arst_n,
	input  efd_pkg::efd_ctrl_t           ctrl,
	output logic                         busy,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [efd_pkg::M_TDATA_W-1:0] m_tdata, // [7:0] payload_byte, [13:8] payload_length
	output logic                         m_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} drain_state_t;

	drain_state_t                    state_q;
	logic [efd_pkg::ADDR_W-1:0]      rd_ptr_q;
	logic [efd_pkg::LEN_W-1:0]       len_q;
	logic [efd_pkg::LEN_W-1:0]       out_len_q;
	logic [efd_pkg::BYTE_W-1:0]      rd_data_q;
	logic                            valid_q;
	logic                            last_q;
	logic [efd_pkg::BYTE_W-1:0]      store_q [efd_pkg::STORE_DEPTH];
	logic                            issue;
	logic                            issue_last;

	// a read is issued only when the output register is free or being emptied
	assign issue      = (state_q == ST_DRAIN) && (!valid_q || m_tready);
	assign issue_last = (efd_pkg::LEN_W'(rd_ptr_q) == (len_q - efd_pkg::LEN_W'(1)));
	assign busy       = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			store_q[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (issue) begin
			rd_data_q <= store_q[rd_ptr_q];
			last_q    <= issue_last;
			out_len_q <= len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_ptr_q <= '0;
			len_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						state_q  <= ST_DRAIN;
						rd_ptr_q <= '0;
						len_q    <= ctrl.start_len;
					end
				end
				ST_DRAIN: begin
					if (issue) begin
						rd_ptr_q <= rd_ptr_q + efd_pkg::ADDR_W'(1);
						if (issue_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (issue) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{efd_pkg::M_PAD_W{1'b0}}, out_len_q, rd_data_q};

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> state_q == ST_IDLE)
		else $error("drain started while busy");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en |-> state_q == ST_IDLE)
		else $error("store written during drain");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && issue_last) |=> state_q == ST_IDLE)
		else $error("drain did not finish on last byte");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> len_q != '0)
		else $error("drain with zero length");

endmodule

// ===== hw/rtl/escaped_frame_deframer_core.sv =====
// Top level of the escaped frame deframer: line byte parser and frame checker.
// Usage notes:
//  - s_* carries one raw line byte per transaction in s_tdata[7:0].
//  - 0x81 opens (or restarts) a frame, 0x82 closes it, 0x80 escapes the
//    following byte so it is stored as data.
//  - A frame of at least two stored bytes whose 8-bit sum is zero comes out
//    on m_* as a run of payload bytes (checksum dropped); m_tlast marks the
//    final byte and m_tdata[13:8] carries the payload length on every byte.
//  - A good end byte triggers a read-out of the frame store, one byte per cycle
//    from its single read port while m_tready is high; the first payload
//    byte is valid after the drain state and its read are registered, and
//    s_tready stays low until the last payload byte has been read.
//  - A bad, short or overflowing frame produces nothing.
//  - m_tdata/m_tlast are registered; when m_tready is low the read-out pauses
//    and the current byte holds. A fresh line byte may be taken while the
//    last payload byte still waits.
//  - Reset clears the parser and drain control; the store needs no clearing
//    since only bytes written by the current frame are ever read.
module escaped_frame_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata, // [7:0] line_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [efd_pkg::M_TDATA_W-1:0] m_tdata, // [7:0] payload_byte, [13:8] payload_length
	output logic                          m_tlast
);

	logic                          esc_q;
	logic                          framing_q;
	logic [efd_pkg::CNT_W-1:0]     cnt_q;
	logic [efd_pkg::BYTE_W-1:0]    sum_q;

	logic                          esc_d;
	logic                          framing_d;
	logic [efd_pkg::CNT_W-1:0]     cnt_d;
	logic [efd_pkg::BYTE_W-1:0]    sum_d;
	logic                          take;
	logic                          store_data;
	logic                          full;
	logic                          busy;
	efd_pkg::efd_ctrl_t            ctrl;

	assign s_tready = !busy;
	assign take     = s_tvalid && s_tready;
	assign full     = (cnt_q >= efd_pkg::CNT_W'(efd_pkg::STORE_DEPTH));

	always_comb begin
		esc_d          = esc_q;
		framing_d      = framing_q;
		cnt_d          = cnt_q;
		sum_d          = sum_q;
		store_data     = 1'b0;
		ctrl.wr_en     = 1'b0;
		ctrl.wr_addr   = cnt_q[efd_pkg::ADDR_W-1:0];
		ctrl.wr_data   = s_tdata;
		ctrl.start     = 1'b0;
		ctrl.start_len = efd_pkg::LEN_W'(cnt_q - efd_pkg::CNT_W'(1));
		if (take) begin
			if (s_tdata == efd_pkg::ESC_CODE && !esc_q) begin
				esc_d = 1'b1;
			end else if (esc_q) begin
				esc_d      = 1'b0;
				store_data = 1'b1;
			end else if (s_tdata == efd_pkg::START_CODE) begin
				framing_d = 1'b1;
				cnt_d     = '0;
				sum_d     = '0;
			end else if (s_tdata != efd_pkg::END_CODE) begin
				store_data = 1'b1;
			end else begin
				ctrl.start = framing_q && (cnt_q >= efd_pkg::CNT_W'(2)) && (sum_q == '0);
				framing_d  = 1'b0;
				cnt_d      = '0;
				sum_d      = '0;
			end
			if (store_data && framing_q) begin
				if (full) begin
					// overflow abandons the frame
					framing_d = 1'b0;
					cnt_d     = '0;
					sum_d     = '0;
				end else begin
					ctrl.wr_en = 1'b1;
					cnt_d      = cnt_q + efd_pkg::CNT_W'(1);
					sum_d      = sum_q + s_tdata;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q     <= 1'b0;
			framing_q <= 1'b0;
			cnt_q     <= '0;
			sum_q     <= '0;
		end else begin
			esc_q     <= esc_d;
			framing_q <= framing_d;
			cnt_q     <= cnt_d;
			sum_q     <= sum_d;
		end
	end

	efd_drain u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= efd_pkg::CNT_W'(efd_pkg::STORE_DEPTH))
		else $error("byte count beyond store depth");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!framing_q |-> (cnt_q == '0 && sum_q == '0))
		else $error("count or sum left over outside a frame");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |=> (!framing_q && cnt_q == '0 && !s_tready))
		else $error("good frame end did not idle parser and stall input");

endmodule
